@@ sv/tcry_pkg.sv @@
// ----------------------------------------------------------------------------
// tcry_pkg
// Shared types and constants of the tone curve and RGB to YUV color converter.
// ----------------------------------------------------------------------------
`default_nettype none

package tcry_pkg;

    // Item kinds carried in the input tuser bit.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    // Curve section selected by table_index[9:8].
    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    // Matrix sums stay within 0..2555000, so 24 signed bits hold them.
    typedef logic signed [23:0] sum_t;

    localparam sum_t KYR = 24'sd2990;
    localparam sum_t KYG = 24'sd5870;
    localparam sum_t KYB = 24'sd1140;
    localparam sum_t KUR = -24'sd1690;
    localparam sum_t KUG = -24'sd3320;
    localparam sum_t KUB = 24'sd5000;
    localparam sum_t KVR = 24'sd5000;
    localparam sum_t KVG = -24'sd4190;
    localparam sum_t KVB = -24'sd813;
    localparam sum_t CHROMA_OFFSET = 24'sd1280000;

    // Division by 10000 as a multiply by ceil(2^34 / 10000) and a shift.
    // The rounding error is 816 / 2^34 per unit, exact for sums below 2^23.
    localparam int        RECIP_W     = 21;
    localparam int        RECIP_SHIFT = 34;
    localparam int        SCALED_W    = 23;
    localparam int        PROD_W      = SCALED_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = 21'd1717987;

    // One write into a 256-entry curve section.
    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } curve_wr_t;

endpackage

`default_nettype wire

@@ sv/tcry_curve_mem.sv @@
// ----------------------------------------------------------------------------
// tcry_curve_mem
// One 256 x 8 tone curve section: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcry_curve_mem (
    input  wire                  clk,
    input  tcry_pkg::curve_wr_t  wr,
    input  wire                  rd_en,
    input  wire  [7:0]           rd_addr,
    output logic [7:0]           rd_data
);
    import tcry_pkg::*;

    logic [7:0] mem [256];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read data only moves when the pixel is taken into the first stage,
    // so a stalled stage keeps its curved value.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/tcry_matrix.sv @@
// ----------------------------------------------------------------------------
// tcry_matrix
// Color matrix: the three scaled Y, U and V sums of one curved pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module tcry_matrix (
    input  wire  [7:0]          r,
    input  wire  [7:0]          g,
    input  wire  [7:0]          b,
    output tcry_pkg::sum_t      sum_y,
    output tcry_pkg::sum_t      sum_u,
    output tcry_pkg::sum_t      sum_v
);
    import tcry_pkg::*;

    sum_t rs;
    sum_t gs;
    sum_t bs;

    assign rs = sum_t'({16'd0, r});
    assign gs = sum_t'({16'd0, g});
    assign bs = sum_t'({16'd0, b});

    assign sum_y = KYR * rs + KYG * gs + KYB * bs;
    assign sum_u = KUR * rs + KUG * gs + KUB * bs + CHROMA_OFFSET;
    assign sum_v = KVR * rs + KVG * gs + KVB * bs + CHROMA_OFFSET;

endmodule

`default_nettype wire

@@ sv/tcry_scale.sv @@
// ----------------------------------------------------------------------------
// tcry_scale
// Divides one matrix sum by 10000, truncating, and clamps it to 0..255.
// ----------------------------------------------------------------------------
`default_nettype none

module tcry_scale (
    input  tcry_pkg::sum_t  sum,
    output logic [7:0]      result
);
    import tcry_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-RECIP_SHIFT-1:0] quot;

    assign prod = PROD_W'(sum[SCALED_W-1:0]) * PROD_W'(RECIP);
    assign quot = prod[PROD_W-1:RECIP_SHIFT];

    always_comb
    begin
        if (sum <= 0)
        begin
            result = 8'd0;
        end
        else if (quot > (PROD_W-RECIP_SHIFT)'(255))
        begin
            result = 8'd255;
        end
        else
        begin
            result = quot[7:0];
        end
    end

endmodule

`default_nettype wire

@@ sv/tone_curve_rgb_to_yuv_core.sv @@
// ----------------------------------------------------------------------------
// tone_curve_rgb_to_yuv_core
// Tone curves per color followed by a BT.601 style RGB to YUV conversion.
// ----------------------------------------------------------------------------
//
//  Port group   Direction  Transfer when           Content
//  s_*          in         s_tvalid & s_tready     curve load or pixel
//  m_*          out        m_tvalid & m_tready     alpha, Y, U, V
//  cfg_*        in         cfg_valid & cfg_ready   channel_order
//
// Three stages: curve lookup, color matrix sums, divide and clamp into the
// output register, which each pixel passes in turn. One pixel per clock
// while m_* does not stall. Load items write the curve memory and give no
// result. The reciprocal multiply in the last stage sets the clock limit.
// A stall on m_* only fills empty stages, so input keeps flowing until all
// three stages hold pixels. Reset clears the stage valids and channel_order;
// curve contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module tone_curve_rgb_to_yuv_core (
    input  wire          clk,
    input  wire          rst_n,
    // cfg_data: channel_order
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [7:0]   cfg_data,
    input  wire          s_tvalid,
    output logic         s_tready,
    // s_tdata: byte_0[7:0], byte_1[15:8], byte_2[23:16], byte_3[31:24],
    //          table_index[41:32], table_value[49:42], zero fill[55:50]
    input  wire  [55:0]  s_tdata,
    // s_tuser: mode[0]
    input  wire  [0:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // m_tdata: out_alpha[7:0], out_y[15:8], out_u[23:16], out_v[31:24]
    output logic [31:0]  m_tdata
);
    import tcry_pkg::*;

    logic [7:0] in_b0;
    logic [7:0] in_b1;
    logic [7:0] in_b2;
    logic [7:0] in_b3;
    logic [9:0] in_idx;
    logic [7:0] in_val;
    logic       in_accept;
    logic       pix_accept;
    logic       load_accept;

    logic       order_reg;
    logic       order_next;

    curve_wr_t  wr_red;
    curve_wr_t  wr_green;
    curve_wr_t  wr_blue;
    logic [7:0] addr_red;
    logic [7:0] addr_blue;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_alpha_reg;
    logic [7:0] s1_r;
    logic [7:0] s1_g;
    logic [7:0] s1_b;

    logic       s2_valid_reg;
    logic       s2_valid_next;
    logic [7:0] s2_alpha_reg;
    sum_t       s2_y_reg;
    sum_t       s2_u_reg;
    sum_t       s2_v_reg;
    sum_t       mat_y;
    sum_t       mat_u;
    sum_t       mat_v;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [31:0] out_data_reg;
    logic [7:0] sc_y;
    logic [7:0] sc_u;
    logic [7:0] sc_v;

    logic       s1_ready;
    logic       s2_ready;
    logic       out_ready;

    assign in_b0  = s_tdata[7:0];
    assign in_b1  = s_tdata[15:8];
    assign in_b2  = s_tdata[23:16];
    assign in_b3  = s_tdata[31:24];
    assign in_idx = s_tdata[41:32];
    assign in_val = s_tdata[49:42];

    // Stage handshakes: a stage loads when it is empty or moves on.
    assign out_ready = !out_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;

    assign s_tready    = s1_ready;
    assign in_accept   = s_tvalid && s_tready;
    assign pix_accept  = in_accept && (s_tuser[0] == MODE_PIXEL);
    assign load_accept = in_accept && (s_tuser[0] == MODE_LOAD);

    assign cfg_ready  = 1'b1;
    assign order_next = (cfg_valid && cfg_ready) ? cfg_data[0] : order_reg;

    // Curve writes; an index past the blue section is dropped.
    always_comb
    begin
        wr_red.en     = load_accept && (in_idx[9:8] == SEC_RED);
        wr_red.addr   = in_idx[7:0];
        wr_red.data   = in_val;
        wr_green.en   = load_accept && (in_idx[9:8] == SEC_GREEN);
        wr_green.addr = in_idx[7:0];
        wr_green.data = in_val;
        wr_blue.en    = load_accept && (in_idx[9:8] == SEC_BLUE);
        wr_blue.addr  = in_idx[7:0];
        wr_blue.data  = in_val;
    end

    assign addr_red  = order_reg ? in_b2 : in_b0;
    assign addr_blue = order_reg ? in_b0 : in_b2;

    tcry_curve_mem u_curve_red (
        .clk     (clk),
        .wr      (wr_red),
        .rd_en   (pix_accept),
        .rd_addr (addr_red),
        .rd_data (s1_r)
    );

    tcry_curve_mem u_curve_green (
        .clk     (clk),
        .wr      (wr_green),
        .rd_en   (pix_accept),
        .rd_addr (in_b1),
        .rd_data (s1_g)
    );

    tcry_curve_mem u_curve_blue (
        .clk     (clk),
        .wr      (wr_blue),
        .rd_en   (pix_accept),
        .rd_addr (addr_blue),
        .rd_data (s1_b)
    );

    tcry_matrix u_matrix (
        .r     (s1_r),
        .g     (s1_g),
        .b     (s1_b),
        .sum_y (mat_y),
        .sum_u (mat_u),
        .sum_v (mat_v)
    );

    tcry_scale u_scale_y (
        .sum    (s2_y_reg),
        .result (sc_y)
    );

    tcry_scale u_scale_u (
        .sum    (s2_u_reg),
        .result (sc_u)
    );

    tcry_scale u_scale_v (
        .sum    (s2_v_reg),
        .result (sc_v)
    );

    assign s1_valid_next  = s1_ready ? pix_accept : s1_valid_reg;
    assign s2_valid_next  = s2_ready ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = out_ready ? s2_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            order_reg     <= order_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_alpha_reg <= in_b3;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_alpha_reg <= s1_alpha_reg;
            s2_y_reg     <= mat_y;
            s2_u_reg     <= mat_u;
            s2_v_reg     <= mat_v;
        end
        if (s2_valid_reg && out_ready)
        begin
            out_data_reg <= {sc_v, sc_u, sc_y, s2_alpha_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ sv/tcry_checker.sv @@
// ----------------------------------------------------------------------------
// tcry_checker
// Port level checks of the color converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcry_checker (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          cfg_valid,
    input  wire          cfg_ready,
    input  wire          s_tvalid,
    input  wire          s_tready,
    input  wire          m_tvalid,
    input  wire          m_tready,
    input  wire  [31:0]  m_tdata
);

    // A result waiting for its transfer stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    // With the output free, the pipeline always has room for an input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input blocked while output is free");

    // Configuration writes are never held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

    // A result only appears after an input transfer has moved through the
    // curve lookup, matrix and output registers of an idle pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !$past(m_tvalid) && !$past(s_tvalid && s_tready, 1)
            && !$past(s_tvalid && s_tready, 2) && !$past(m_tvalid, 2)
            && !$past(s_tvalid && s_tready, 3) && !$past(m_tvalid, 3)
            |=> !m_tvalid)
        else $error("result appeared without a pixel");

endmodule

bind tone_curve_rgb_to_yuv_core tcry_checker u_tcry_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tone curve and RGB to YUV converter. The curve
// memory is loaded completely before any pixel is sent. Directed pixels then
// hit the corners of the color cube in both channel orders, and out-of-range
// loads are checked to leave the curves alone. A random mix of pixels and
// curve rewrites follows under several channel orders. A shadow copy of the
// curves and the conversion arithmetic predicts every output transfer.
// Random gaps are inserted on the input and output streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    import tcry_pkg::*;

    localparam logic ORDER_RGBA   = 1'b0;
    localparam logic ORDER_BGRA   = 1'b1;
    localparam int   CURVE_DEPTH  = 768;
    localparam int   DRAIN_CYCLES = 8;
    localparam int   LIMIT_CYCLES = 1000000;
    localparam int   RANDOM_SEGS  = 5;
    localparam int   SEG_ITEMS    = 52;

    typedef struct packed {
        logic [7:0] v;
        logic [7:0] u;
        logic [7:0] y;
        logic [7:0] alpha;
    } yuv_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    logic [7:0]  curve_shadow [0:CURVE_DEPTH-1];
    logic        order_shadow;
    yuv_t        yuv_q [$];
    int          fail_count;
    int          cycle_count;
    bit          idle_on;

    tone_curve_rgb_to_yuv_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Most idle stretches are short; a few are long.
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return $urandom_range(1, 2);
        else if (p < 90)
            return $urandom_range(3, 6);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] div_clip(input int sum);
        int q;
        if (sum <= 0)
            return 8'd0;
        q = sum / 10000;
        if (q > 255)
            q = 255;
        return q[7:0];
    endfunction

    function automatic yuv_t predict_yuv(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3);
        yuv_t res;
        logic [7:0] r_in;
        logic [7:0] b_in;
        int r;
        int g;
        int b;
        if (order_shadow == ORDER_BGRA)
        begin
            r_in = b2;
            b_in = b0;
        end
        else
        begin
            r_in = b0;
            b_in = b2;
        end
        r = curve_shadow[{SEC_RED, r_in}];
        g = curve_shadow[{SEC_GREEN, b1}];
        b = curve_shadow[{SEC_BLUE, b_in}];
        res.alpha = b3;
        res.y = div_clip(2990 * r + 5870 * g + 1140 * b);
        res.u = div_clip(-1690 * r - 3320 * g + 5000 * b + 1280000);
        res.v = div_clip(5000 * r - 4190 * g - 813 * b + 1280000);
        return res;
    endfunction

    task automatic report_error(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // One item on the input stream; the shadow state follows each transfer.
    task automatic send_item(input logic mode, input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3,
                             input logic [9:0] idx, input logic [7:0] val);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'd0, val, idx, b3, b2, b1, b0};
        do
            @(posedge clk);
        while (!s_tready);
        if (mode == MODE_LOAD)
        begin
            if (idx < CURVE_DEPTH)
                curve_shadow[idx] = val;
        end
        else
            yuv_q.push_back(predict_yuv(b0, b1, b2, b3));
    endtask

    task automatic send_pixel(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3);
        send_item(MODE_PIXEL, b0, b1, b2, b3, 10'($urandom), 8'($urandom));
    endtask

    task automatic send_load(input logic [9:0] idx, input logic [7:0] val);
        send_item(MODE_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  idx, val);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (yuv_q.size() != 0)
            @(posedge clk);
        // A trailing load is already written into the curve memory by its transfer.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_order(input logic [7:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        order_shadow = value[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Section ends hold 0 and 255 so that corner pixels reach the extremes.
    task automatic test_curve_fill();
        logic [7:0] val;
        for (int i = 0; i < CURVE_DEPTH; i++)
        begin
            val = 8'($urandom);
            if (i[7:0] == 8'd0)
                val = 8'd0;
            else if (i[7:0] == 8'd255)
                val = 8'd255;
            send_load(10'(i), val);
        end
    endtask

    task automatic test_corners();
        send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd0,   8'h5a);
        send_pixel(8'd0,   8'd255, 8'd0,   8'ha5);
        send_pixel(8'd0,   8'd0,   8'd255, 8'h0f);
        send_pixel(8'd255, 8'd255, 8'd0,   8'hf0);
        send_pixel(8'd0,   8'd255, 8'd255, 8'h33);
        send_pixel(8'd255, 8'd0,   8'd255, 8'hcc);
    endtask

    // Loads above the last entry must not alias into any curve section.
    task automatic test_ignored_loads();
        send_load(10'd768, 8'haa);
        send_load(10'd1023, 8'h55);
        send_pixel(8'd0, 8'd0, 8'd0, 8'h11);
        send_pixel(8'd255, 8'd255, 8'd255, 8'h22);
    endtask

    task automatic test_channel_order();
        write_order({7'($urandom), ORDER_BGRA});
        test_corners();
        write_order({7'd0, ORDER_RGBA});
        send_pixel(8'd255, 8'd0, 8'd0, 8'h44);
    endtask

    task automatic test_random();
        int p;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        for (int seg = 0; seg < RANDOM_SEGS; seg++)
        begin
            write_order({7'($urandom), 1'($urandom)});
            idle_on = (seg % 2 == 1);
            for (int i = 0; i < SEG_ITEMS; i++)
            begin
                p = $urandom_range(0, 99);
                if (p < 70)
                begin
                    b0 = 8'($urandom);
                    b1 = 8'($urandom);
                    b2 = 8'($urandom);
                    if ($urandom_range(0, 9) == 0)
                    begin
                        b0 = {8{b0[0]}};
                        b1 = {8{b1[0]}};
                        b2 = {8{b2[0]}};
                    end
                    send_pixel(b0, b1, b2, 8'($urandom));
                end
                else if (p < 95)
                    send_load(10'($urandom_range(0, CURVE_DEPTH - 1)), 8'($urandom));
                else
                    send_load(10'($urandom_range(CURVE_DEPTH, 1023)), 8'($urandom));
            end
        end
        idle_on = 1'b1;
    endtask

    // Output side: ready bursts broken by random stalls.
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                n = idle_len();
                repeat (n)
                begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                end
            end
            n = $urandom_range(1, 8);
            repeat (n)
            begin
                @(negedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        yuv_t want;
        yuv_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (yuv_q.size() == 0)
                report_error($sformatf("Unexpected result transfer: %h", got));
            else
            begin
                want = yuv_q.pop_front();
                if (got.alpha !== want.alpha || got.y !== want.y ||
                    got.u !== want.u || got.v !== want.v)
                    report_error($sformatf(
                        "Mismatch: expected a=%h y=%h u=%h v=%h, got a=%h y=%h u=%h v=%h",
                        want.alpha, want.y, want.u, want.v,
                        got.alpha, got.y, got.u, got.v));
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 8'd0;
        s_tvalid     = 1'b0;
        s_tdata      = 56'd0;
        s_tuser      = MODE_LOAD;
        order_shadow = ORDER_RGBA;
        fail_count   = 0;
        cycle_count  = 0;
        idle_on      = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_curve_fill();
        test_corners();
        test_ignored_loads();
        test_channel_order();
        test_random();
        wait_drained();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
